[design/permutation_unrank_core_defines.svh]
// Assertion macros shared by the permutation unrank checker.
// Depends on nothing; the using module must have clk and arst_n in scope.
`ifndef PERMUTATION_UNRANK_CORE_DEFINES_SVH
`define PERMUTATION_UNRANK_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is held.
`define PU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("permutation unrank check failed");

// Next-cycle implication, sampled on clk, off while reset is held.
`define PU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("permutation unrank check failed");

`endif

[design/pu_pkg.sv]
// Shared constants, types and helper functions of the permutation unrank core.
// Used by the cell and the top level; depends on nothing.
package pu_pkg;

	localparam int N_ELEMENTS = 9;
	localparam int MAX_ELEMS  = 10;
	localparam int POS_FIELDS = 9;
	localparam int RANK_W     = 19;
	localparam int ELEM_W     = 4;
	localparam int DIG_W      = 4;
	localparam int IDX_W      = (N_ELEMENTS > 1) ? $clog2(N_ELEMENTS) : 1;

	localparam int IN_TDATA_W  = ((RANK_W + 7) / 8) * 8;
	localparam int POS_W       = POS_FIELDS * ELEM_W;
	localparam int OUT_TDATA_W = ((POS_W + 7) / 8) * 8;
	localparam int IN_PAD_W    = IN_TDATA_W - RANK_W;
	localparam int OUT_PAD_W   = OUT_TDATA_W - POS_W;

	function automatic int fact(input int k);
		int f;
		f = 1;
		for (int i = 2; i <= MAX_ELEMS; i++) begin
			if (i <= k) begin
				f = f * i;
			end
		end
		return f;
	endfunction

	localparam int FACT_N = fact(N_ELEMENTS);
	localparam int THR_W  = $clog2(FACT_N + 1);
	localparam int CMP_W  = (THR_W > RANK_W) ? THR_W : RANK_W;

	typedef logic [POS_FIELDS-1:0][ELEM_W-1:0] pu_pos_t;

	// What travels from one cell to the next.
	typedef struct packed {
		logic [RANK_W-1:0]     rem;
		logic [N_ELEMENTS-1:0] used;
		pu_pos_t               pos;
		logic                  err;
	} pu_item_t;

endpackage

[design/pu_cell.sv]
// One cell of the unrank chain: extracts one factorial digit and picks one element.
// Depends on pu_pkg.
module pu_cell
	import pu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [IDX_W-1:0] cell_idx,
	input  logic             in_valid,
	input  pu_item_t         in_item,
	output logic             out_valid,
	output pu_item_t         out_item
);

	logic                               valid_q;
	pu_item_t                           item_q;
	pu_item_t                           nxt;
	logic [N_ELEMENTS-1:0]              ge;
	logic [N_ELEMENTS-1:0][CMP_W-1:0]   thr;
	logic [DIG_W-1:0]                   digit;
	logic [CMP_W-1:0]                   rem_ext;
	logic [CMP_W-1:0]                   sub;
	logic [ELEM_W-1:0]                  pick;
	logic [N_ELEMENTS-1:0]              pick_hot;
	logic [DIG_W-1:0]                   free_below;
	int                                 idx;

	// The digit is the number of multiples of the weight that fit in the
	// remaining rank. The multiples come from a constant table selected by
	// the cell index, so no factorial is computed in logic.
	always_comb begin
		idx     = int'(cell_idx);
		rem_ext = CMP_W'(in_item.rem);
		thr     = '0;
		for (int c = 0; c < N_ELEMENTS; c++) begin
			if (idx == c) begin
				for (int k = 1; k < N_ELEMENTS - c; k++) begin
					thr[k] = CMP_W'(k * fact(N_ELEMENTS - 1 - c));
				end
			end
		end
		ge = '0;
		for (int k = 1; k < N_ELEMENTS; k++) begin
			ge[k] = (k < N_ELEMENTS - idx) && (rem_ext >= thr[k]);
		end
		digit = DIG_W'($countones(ge));
		sub   = '0;
		for (int k = 1; k < N_ELEMENTS; k++) begin
			if (digit == DIG_W'(k)) begin
				sub = thr[k];
			end
		end
	end

	// Select the element that has exactly digit free elements below it.
	always_comb begin
		pick     = '0;
		pick_hot = '0;
		for (int j = 0; j < N_ELEMENTS; j++) begin
			free_below = '0;
			for (int m = 0; m < j; m++) begin
				if (!in_item.used[m]) begin
					free_below = free_below + DIG_W'(1);
				end
			end
			if (!in_item.used[j] && free_below == digit) begin
				pick        = ELEM_W'(j);
				pick_hot[j] = 1'b1;
			end
		end
	end

	always_comb begin
		nxt = in_item;
		if (!in_item.err) begin
			nxt.rem  = RANK_W'(rem_ext - sub);
			nxt.used = in_item.used | pick_hot;
			for (int p = 0; p < POS_FIELDS; p++) begin
				if (idx == p) begin
					nxt.pos[p] = pick;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

[design/permutation_unrank_core.sv]
// Structure: a chain of pu_cell registers from an accepted request to m_tvalid, one cell per position.
// Throughput: one request per cycle while the output is not stalled; the last cell is the output register, and
// while its result is not taken the whole chain of cells holds still.
// Reset: arst_n clears every cell's valid bit at once; the payload is not reset.
// Depends on pu_pkg and pu_cell.
module permutation_unrank_core
	import pu_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [18:0] rank
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // pos_0 [3:0] up to pos_8 [35:32]
	output logic                   m_tuser   // [0] rank_error
);

	logic                en;
	logic [N_ELEMENTS:0] valid_c;
	pu_item_t            item_c [0:N_ELEMENTS];
	logic [RANK_W-1:0]   rank;

	assign rank = s_tdata[RANK_W-1:0];
	assign en   = !valid_c[N_ELEMENTS] || m_tready;

	always_comb begin
		item_c[0].rem  = rank;
		item_c[0].used = '0;
		item_c[0].pos  = '0;
		item_c[0].err  = CMP_W'(rank) >= CMP_W'(FACT_N);
	end
	assign valid_c[0] = s_tvalid;

	for (genvar k = 0; k < N_ELEMENTS; k++) begin : g_cell
		pu_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.cell_idx  (IDX_W'(k)),
			.in_valid  (valid_c[k]),
			.in_item   (item_c[k]),
			.out_valid (valid_c[k+1]),
			.out_item  (item_c[k+1])
		);
	end

	assign s_tready = en;
	assign m_tvalid = valid_c[N_ELEMENTS];
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, item_c[N_ELEMENTS].pos};
	assign m_tuser  = item_c[N_ELEMENTS].err;

endmodule

[design/pu_checker.sv]
// Port-level checks for permutation_unrank_core, attached by the bind below.
// Depends on pu_pkg and the macros in permutation_unrank_core_defines.svh.
`include "permutation_unrank_core_defines.svh"

module pu_checker
	import pu_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TDATA_W-1:0]  s_tdata,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser
);

	// A stalled result keeps its contents.
	`PU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// Requests are refused only while the output is blocked.
	`PU_ASSERT_NOW(a_ready_stall, !s_tready, m_tvalid && !m_tready)

	// An out-of-range rank reports all positions as zero.
	`PU_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser, m_tdata == '0)

	// A valid permutation never repeats its first two elements.
	`PU_ASSERT_NOW(a_distinct, m_tvalid && !m_tuser, m_tdata[3:0] != m_tdata[7:4])

	// An accepted request carries fully known data.
	`PU_ASSERT_NOW(a_in_known, s_tvalid && s_tready, !$isunknown(s_tdata))

endmodule

bind permutation_unrank_core pu_checker u_pu_checker (.*);

[tb/tb_permutation_unrank_core.sv]
// Self-checking testbench for permutation_unrank_core: each rank request is
// checked against a lexicographic unranking predictor, under varied idling.
// Depends on pu_pkg and the permutation_unrank_core RTL.
module tb_permutation_unrank_core;
	import pu_pkg::*;

	// One expected permutation, kept with the rank that produced it.
	typedef struct {
		logic [RANK_W-1:0] rank;
		pu_pos_t           pos;
		logic              err;
	} perm_result_t;

	localparam int MAX_RANK = (1 << RANK_W) - 1;
	localparam int MAX_REPORTED = 10;

	// Factorials of 1 to 9: the digit weights and the range limit.
	localparam int unsigned FACT_EDGES [9] = '{1, 2, 6, 24, 120, 720, 5040, 40320, 362880};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [18:0] rank
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // pos_0 [3:0] up to pos_8 [35:32]
	logic                   m_tuser;        // [0] rank_error

	perm_result_t pending_perms [$];
	int mismatch_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	permutation_unrank_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Factorial-base unranking over N_ELEMENTS elements; positions past the
	// element count stay zero and an out-of-range rank gives all zeros.
	function automatic perm_result_t unrank_perm(input logic [RANK_W-1:0] rank);
		perm_result_t res;
		int n;
		int rem;
		int limit;
		int weight;
		int digit;
		int pick;
		bit found;
		bit taken [MAX_ELEMS];
		n = N_ELEMENTS;
		if (n < 1) n = 1;
		if (n > MAX_ELEMS) n = MAX_ELEMS;
		res.rank = rank;
		res.pos = '0;
		res.err = 1'b0;
		foreach (taken[j]) taken[j] = 1'b0;
		limit = 1;
		for (int k = 2; k <= n; k++) limit *= k;
		rem = int'(rank);
		if (rem >= limit) begin
			res.err = 1'b1;
			return res;
		end
		for (int i = 0; i < n; i++) begin
			weight = 1;
			for (int k = 2; k <= n - 1 - i; k++) weight *= k;
			digit = rem / weight;
			rem = rem % weight;
			pick = 0;
			found = 1'b0;
			for (int j = 0; j < n; j++) begin
				if (!taken[j]) begin
					if (digit == 0) begin
						pick = j;
						found = 1'b1;
						break;
					end
					digit--;
				end
			end
			if (found) taken[pick] = 1'b1;
			if (i < POS_FIELDS) res.pos[i] = pick[ELEM_W-1:0];
		end
		return res;
	endfunction

	task automatic note_mismatch(input string field, input logic [RANK_W-1:0] rank,
			input int exp_val, input int act_val);
		if (mismatch_count < MAX_REPORTED) begin
			$display("mismatch on %s for rank %0d: expected %0d, got %0d",
				field, rank, exp_val, act_val);
		end
		mismatch_count++;
	endtask

	// Result checker: every accepted result is matched to the oldest request.
	always @(posedge clk) begin
		perm_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_perms.size() == 0) begin
				note_mismatch("unexpected result", '0, -1, int'(m_tuser));
			end else begin
				want = pending_perms.pop_front();
				for (int i = 0; i < POS_FIELDS; i++) begin
					if (m_tdata[ELEM_W*i +: ELEM_W] !== want.pos[i]) begin
						note_mismatch($sformatf("pos_%0d", i), want.rank,
							int'(want.pos[i]), int'(m_tdata[ELEM_W*i +: ELEM_W]));
					end
				end
				if (m_tuser !== want.err) begin
					note_mismatch("rank_error", want.rank, int'(want.err), int'(m_tuser));
				end
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// Valid is left high after acceptance so back-to-back requests never
	// lower and raise it in the same step.
	task automatic send_rank(input logic [RANK_W-1:0] rank);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_W'(rank);
		do @(posedge clk); while (!s_tready);
		pending_perms.push_back(unrank_perm(rank));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_perms.size() != 0);
	endtask

	function automatic logic [RANK_W-1:0] random_rank();
		int unsigned edge_val;
		case ($urandom_range(0, 9))
			7: begin
				edge_val = FACT_EDGES[$urandom_range(0, 8)];
				return RANK_W'(edge_val + $urandom_range(0, 2) - 1);
			end
			8: return RANK_W'($urandom_range(FACT_EDGES[8], MAX_RANK));
			9: return RANK_W'($urandom);
			default: return RANK_W'($urandom_range(0, FACT_EDGES[8] - 1));
		endcase
	endfunction

	// Factorial boundaries, the last valid rank, the first invalid ones and
	// alternating bit patterns.
	task automatic test_directed();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		send_rank(0);
		foreach (FACT_EDGES[i]) begin
			send_rank(RANK_W'(FACT_EDGES[i] - 1));
			send_rank(RANK_W'(FACT_EDGES[i]));
		end
		send_rank(RANK_W'(FACT_EDGES[8] + 1));
		send_rank(RANK_W'(MAX_RANK));
		send_rank(RANK_W'('h55555));
		send_rank(RANK_W'('h2AAAA));
		wait_drained();
	endtask

	// The sender holds off until the whole pipeline has emptied, then resumes.
	task automatic test_pause_until_drained();
		sender_idle_pct = 0;
		receiver_stall_pct = 55;
		repeat (16) send_rank(random_rank());
		wait_drained();
		repeat (16) send_rank(random_rank());
		wait_drained();
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		repeat (count) send_rank(random_rank());
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pause_until_drained();
		test_random_phase(0, 0, 300);
		test_random_phase(55, 0, 300);
		test_random_phase(0, 55, 300);
		test_random_phase(36, 36, 300);
		wait_drained();
		repeat (2 * N_ELEMENTS) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
